FILE: src/sha1_hash_core_top_assert.svh
// assertion macros used by the sha1 hash core checker
`ifndef SHA1_HASH_CORE_TOP_ASSERT_SVH
`define SHA1_HASH_CORE_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while reset is low
`define SHA1_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off while reset is low
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/sha1_pkg.sv
// types and constants of the sha1 hash core
package sha1_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_vars;

    localparam t_vars H_INIT = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476,
        e: 32'hc3d2e1f0
    };

    localparam t_word K_0 = 32'h5a827999;
    localparam t_word K_1 = 32'h6ed9eba1;
    localparam t_word K_2 = 32'h8f1bbcdc;
    localparam t_word K_3 = 32'hca62c1d6;

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] ROUND_G1   = 7'd20;
    localparam logic [6:0] ROUND_G2   = 7'd40;
    localparam logic [6:0] ROUND_G3   = 7'd60;

    localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

FILE: src/sha1_round.sv
// one sha1 compression round, reused for all 80 rounds
module sha1_round
    import sha1_pkg::*;
(
    input  t_vars      i_vars,
    input  t_word      i_w,
    input  logic [6:0] i_round,
    output t_vars      o_vars
);

    t_word f_val;
    t_word k_val;

    always_comb begin
        if (i_round < ROUND_G1) begin
            f_val = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            k_val = K_0;
        end else if (i_round < ROUND_G2) begin
            f_val = i_vars.b ^ i_vars.c ^ i_vars.d;
            k_val = K_1;
        end else if (i_round < ROUND_G3) begin
            f_val = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            k_val = K_2;
        end else begin
            f_val = i_vars.b ^ i_vars.c ^ i_vars.d;
            k_val = K_3;
        end
    end

    always_comb begin
        o_vars.a = {i_vars.a[26:0], i_vars.a[31:27]} + f_val + i_vars.e + k_val + i_w;
        o_vars.b = i_vars.a;
        o_vars.c = {i_vars.b[1:0], i_vars.b[31:2]};
        o_vars.d = i_vars.c;
        o_vars.e = i_vars.d;
    end

endmodule

FILE: src/sha1_hash_core_top.sv
// sha1 hash core: byte stream in, five digest words out
// Bytes are taken one per cycle into a 512-bit block register; when the block is full
// the core stops taking items and runs the shared round unit once per cycle for 80
// rounds, then folds the result into the chaining value. On the item that ends a
// message the core pads in place at one byte per cycle (0x80, zero fill, then the
// 64-bit bit length), compresses one or two final blocks, and then offers the five
// digest words, word 0 first, one per accepted output item. The input side is not
// ready while a full block is compressed, and from the item that ends a message until
// the last digest word has been taken; afterwards the core is back at the initial
// chaining values and a zero length, ready for the next message.
module sha1_hash_core_top
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [5:0] POS_LEN  = 6'd56;
    localparam logic [5:0] POS_LAST = 6'd63;
    localparam logic [2:0] IDX_LAST = 3'd4;

    logic [2:0]   r_state, n_state;
    logic [2:0]   r_after, n_after;
    logic [511:0] r_blk, n_blk;
    logic [5:0]   r_pos, n_pos;
    logic [60:0]  r_cnt, n_cnt;
    logic         r_mark, n_mark;
    logic [6:0]   r_round, n_round;
    logic [2:0]   r_idx, n_idx;
    t_vars        r_h, n_h;
    t_vars        r_vars, n_vars;

    t_vars        round_vars;
    t_word        sched_x;
    t_word        sched_w;
    logic         in_acc;

    // window word i sits at r_blk[511-32*i -: 32]; word 0 is the current round's word
    assign sched_x = r_blk[511:480] ^ r_blk[447:416] ^ r_blk[255:224] ^ r_blk[95:64];
    assign sched_w = {sched_x[30:0], sched_x[31]};

    sha1_round u_round (
        .i_vars  (r_vars),
        .i_w     (r_blk[511:480]),
        .i_round (r_round),
        .o_vars  (round_vars)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = r_idx;
    assign m_axis_tlast  = (r_idx == IDX_LAST);

    always_comb begin
        unique case (r_idx)
            3'd0:    m_axis_tdata = r_h.a;
            3'd1:    m_axis_tdata = r_h.b;
            3'd2:    m_axis_tdata = r_h.c;
            3'd3:    m_axis_tdata = r_h.d;
            default: m_axis_tdata = r_h.e;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_blk   = r_blk;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_mark  = r_mark;
        n_round = r_round;
        n_idx   = r_idx;
        n_h     = r_h;
        n_vars  = r_vars;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tlast) begin
                        n_mark = 1'b1;
                    end
                    if (s_axis_tuser) begin
                        n_blk = {r_blk[503:0], s_axis_tdata};
                        n_pos = r_pos + 6'd1;
                        n_cnt = r_cnt + 61'd1;
                    end
                    if (s_axis_tuser && r_pos == POS_LAST) begin
                        n_state = S_ROUND;
                        n_after = s_axis_tlast ? S_PAD : S_IDLE;
                        n_vars  = r_h;
                        n_round = '0;
                    end else if (s_axis_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_pos == POS_LEN && !r_mark) begin
                    // length in bits, big-endian, fills words 14 and 15
                    n_blk   = {r_blk[447:0], r_cnt, 3'b000};
                    n_state = S_ROUND;
                    n_after = S_OUT;
                    n_vars  = r_h;
                    n_round = '0;
                end else begin
                    n_blk  = {r_blk[503:0], (r_mark ? PAD_MARK : 8'h00)};
                    n_mark = 1'b0;
                    n_pos  = r_pos + 6'd1;
                    if (r_pos == POS_LAST) begin
                        n_state = S_ROUND;
                        n_after = S_PAD;
                        n_vars  = r_h;
                        n_round = '0;
                    end
                end
            end
            S_ROUND: begin
                n_vars  = round_vars;
                n_blk   = {r_blk[479:0], sched_w};
                n_round = r_round + 7'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_h.a   = r_h.a + r_vars.a;
                n_h.b   = r_h.b + r_vars.b;
                n_h.c   = r_h.c + r_vars.c;
                n_h.d   = r_h.d + r_vars.d;
                n_h.e   = r_h.e + r_vars.e;
                n_state = r_after;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    if (r_idx == IDX_LAST) begin
                        n_idx   = '0;
                        n_h     = H_INIT;
                        n_cnt   = '0;
                        n_pos   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_mark  <= 1'b0;
            r_round <= '0;
            r_idx   <= '0;
            r_h     <= H_INIT;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_mark  <= n_mark;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_h     <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk  <= n_blk;
        r_vars <= n_vars;
    end

endmodule

FILE: src/sha1_chk.sv
// port-level checker for the sha1 hash core, bound to the top level
`include "sha1_hash_core_top_assert.svh"

module sha1_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic       out_acc;
    logic       mid_acc;
    logic       end_acc;
    logic       word4;
    logic [2:0] idx_up;

    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign mid_acc = out_acc && !m_axis_tlast;
    assign end_acc = out_acc && m_axis_tlast;
    assign word4   = (m_axis_tuser == 3'd4);
    assign idx_up  = m_axis_tuser + 3'd1;

    // input side closed while digest words are offered
    `SHA1_ASSERT_NOW(a_no_overlap, s_axis_tready, !m_axis_tvalid, "ready while digest pending")

    // tlast marks exactly word four
    `SHA1_ASSERT_NOW(a_last_idx, m_axis_tvalid, m_axis_tlast == word4, "tlast/index mismatch")

    // words follow each other with rising index
    `SHA1_ASSERT_NEXT(a_step, mid_acc, m_axis_tvalid && m_axis_tuser == $past(idx_up), "order")

    // after the final word the core takes bytes again
    `SHA1_ASSERT_NEXT(a_back_idle, end_acc, s_axis_tready && !m_axis_tvalid, "not idle")

endmodule

bind sha1_hash_core_top sha1_chk u_sha1_chk (.*);
